// ----- rtl/box_shared_face_overlap_core_macros.svh -----
// ----------------------------------------------------------------------------
// box_shared_face_overlap_core_macros
// assertion macros shared by the face overlap block; empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef BOX_SHARED_FACE_OVERLAP_CORE_MACROS_SVH
`define BOX_SHARED_FACE_OVERLAP_CORE_MACROS_SVH

`ifndef SYNTH
// condition must hold in the same cycle
`define BSFO_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsfo assertion failed");
// condition must hold in the following cycle
`define BSFO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsfo assertion failed");
`else
`define BSFO_ASSERT_SAME(label, ante, cons)
`define BSFO_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/bsfo_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfo_pkg
// types, codes and helpers of the shared face overlap block
// ----------------------------------------------------------------------------
package bsfo_pkg;

	localparam int unsigned COORD_W          = 32;
	localparam int unsigned ID_W             = 16;
	localparam int unsigned FACE_W           = 3;
	localparam int unsigned FACE_COUNT       = 6;
	localparam int unsigned CFG_IDX_W        = 3;
	localparam int unsigned BSFO_QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAX_Z = 3'd5;

	// face codes, also the bit positions of the hit mask
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
	localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
	localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
	localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd4;
	localparam logic [FACE_W-1:0] FACE_BACK   = 3'd5;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [FACE_COUNT-1:0]     face_mask_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} own_box_t;

	// one classified item: touching faces and clamped overlap per axis
	typedef struct packed {
		face_mask_t      mask;
		coord_t          lo_x;
		coord_t          lo_y;
		coord_t          lo_z;
		coord_t          hi_x;
		coord_t          hi_y;
		coord_t          hi_z;
		logic [ID_W-1:0] id;
	} q_entry_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	// axis on which a face lies
	function automatic logic [1:0] face_axis(input logic [FACE_W-1:0] face);
		logic [1:0] ax;
		case (face)
			FACE_TOP, FACE_BOTTOM: ax = AXIS_Y;
			FACE_LEFT, FACE_RIGHT: ax = AXIS_X;
			default:               ax = AXIS_Z;
		endcase
		return ax;
	endfunction

endpackage

// ----- rtl/bsfo_box_if.sv -----
// ----------------------------------------------------------------------------
// bsfo_box_if
// input channel: the other box, its id and the same-box flag
// ----------------------------------------------------------------------------
interface bsfo_box_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] other_min_x;
	logic signed [31:0] other_min_y;
	logic signed [31:0] other_min_z;
	logic signed [31:0] other_max_x;
	logic signed [31:0] other_max_y;
	logic signed [31:0] other_max_z;
	logic [15:0]        other_id;
	logic               same_box;

	modport source (
		output valid, other_min_x, other_min_y, other_min_z,
		output other_max_x, other_max_y, other_max_z, other_id, same_box,
		input  ready
	);
	modport sink (
		input  valid, other_min_x, other_min_y, other_min_z,
		input  other_max_x, other_max_y, other_max_z, other_id, same_box,
		output ready
	);
endinterface

// ----- rtl/bsfo_rect_if.sv -----
// ----------------------------------------------------------------------------
// bsfo_rect_if
// output channel: one shared rectangle per transfer
// ----------------------------------------------------------------------------
interface bsfo_rect_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] rect_min_x;
	logic signed [31:0] rect_min_y;
	logic signed [31:0] rect_min_z;
	logic signed [31:0] rect_max_x;
	logic signed [31:0] rect_max_y;
	logic signed [31:0] rect_max_z;
	logic [2:0]         face_code;
	logic [15:0]        linked_id;
	logic               last_of_run;

	modport source (
		output valid, rect_min_x, rect_min_y, rect_min_z,
		output rect_max_x, rect_max_y, rect_max_z, face_code, linked_id, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, rect_min_x, rect_min_y, rect_min_z,
		input  rect_max_x, rect_max_y, rect_max_z, face_code, linked_id, last_of_run,
		output ready
	);
endinterface

// ----- rtl/bsfo_front.sv -----
// ----------------------------------------------------------------------------
// bsfo_front
// accepts boxes, finds touching faces and clamps the overlap per axis
// ----------------------------------------------------------------------------
module bsfo_front (
	bsfo_box_if.sink            box_in,
	input  bsfo_pkg::own_box_t  own,
	input  logic                q_full,
	output logic                q_push,
	output bsfo_pkg::q_entry_t  q_data
);
	import bsfo_pkg::*;

	face_mask_t mask;

	// a new box is taken whenever the queue has room
	assign box_in.ready = !q_full;

	// exact face contact tests
	always_comb begin
		mask              = '0;
		mask[FACE_TOP]    = (own.max_y == box_in.other_min_y);
		mask[FACE_BOTTOM] = (own.min_y == box_in.other_max_y);
		mask[FACE_LEFT]   = (own.max_x == box_in.other_min_x);
		mask[FACE_RIGHT]  = (own.min_x == box_in.other_max_x);
		mask[FACE_FRONT]  = (own.max_z == box_in.other_min_z);
		mask[FACE_BACK]   = (own.min_z == box_in.other_max_z);
	end

	// clamped overlap: larger minimum, smaller maximum
	always_comb begin
		q_data.mask = mask;
		q_data.lo_x = (box_in.other_min_x < own.min_x) ? own.min_x : box_in.other_min_x;
		q_data.lo_y = (box_in.other_min_y < own.min_y) ? own.min_y : box_in.other_min_y;
		q_data.lo_z = (box_in.other_min_z < own.min_z) ? own.min_z : box_in.other_min_z;
		q_data.hi_x = (own.max_x < box_in.other_max_x) ? own.max_x : box_in.other_max_x;
		q_data.hi_y = (own.max_y < box_in.other_max_y) ? own.max_y : box_in.other_max_y;
		q_data.hi_z = (own.max_z < box_in.other_max_z) ? own.max_z : box_in.other_max_z;
		q_data.id   = box_in.other_id;
	end

	// boxes with no touching face or flagged as the held box are dropped here
	assign q_push = box_in.valid && !q_full && !box_in.same_box && (mask != '0);

endmodule

// ----- rtl/bsfo_queue.sv -----
// ----------------------------------------------------------------------------
// bsfo_queue
// short fifo of classified boxes between front and back
// ----------------------------------------------------------------------------
module bsfo_queue #(
	parameter int unsigned DEPTH = bsfo_pkg::BSFO_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bsfo_pkg::q_entry_t push_data,
	input  logic               pop,
	output logic               full,
	output bsfo_pkg::q_head_t  head
);
	import bsfo_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/bsfo_back.sv -----
// ----------------------------------------------------------------------------
// bsfo_back
// walks the touching faces of the queue head, one rectangle per cycle unless rect_out stalls
// ----------------------------------------------------------------------------
`include "box_shared_face_overlap_core_macros.svh"

module bsfo_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bsfo_pkg::own_box_t own,
	input  bsfo_pkg::q_head_t head,
	output logic              pop,
	bsfo_rect_if.source       rect_out
);
	import bsfo_pkg::*;

	face_mask_t        done_q;
	face_mask_t        rem;
	face_mask_t        pick_oh;
	face_mask_t        rest;
	logic [FACE_W-1:0] pick;
	logic              emit;
	logic [1:0]        ax;
	coord_t            coord;

	logic              out_valid_q;
	coord_t            min_x_q, min_y_q, min_z_q;
	coord_t            max_x_q, max_y_q, max_z_q;
	logic [FACE_W-1:0] face_q;
	logic [ID_W-1:0]   id_q;
	logic              last_q;

	// lowest pending face first
	assign rem = head.entry.mask & ~done_q;

	always_comb begin
		pick    = '0;
		pick_oh = '0;
		for (int f = FACE_COUNT - 1; f >= 0; f--) begin
			if (rem[f]) begin
				pick    = FACE_W'(f);
				pick_oh = face_mask_t'(1) << f;
			end
		end
	end

	assign rest = rem & ~pick_oh;
	assign emit = head.valid && (!out_valid_q || rect_out.ready);
	assign pop  = emit && (rest == '0);
	assign ax   = face_axis(pick);

	// held face coordinate
	always_comb begin
		case (pick)
			FACE_TOP:    coord = own.max_y;
			FACE_BOTTOM: coord = own.min_y;
			FACE_LEFT:   coord = own.max_x;
			FACE_RIGHT:  coord = own.min_x;
			FACE_FRONT:  coord = own.max_z;
			default:     coord = own.min_z;
		endcase
	end

	// faces already sent for the current head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (emit) begin
			done_q <= pop ? face_mask_t'(0) : (done_q | pick_oh);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rect_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			min_x_q <= (ax == AXIS_X) ? coord : head.entry.lo_x;
			max_x_q <= (ax == AXIS_X) ? coord : head.entry.hi_x;
			min_y_q <= (ax == AXIS_Y) ? coord : head.entry.lo_y;
			max_y_q <= (ax == AXIS_Y) ? coord : head.entry.hi_y;
			min_z_q <= (ax == AXIS_Z) ? coord : head.entry.lo_z;
			max_z_q <= (ax == AXIS_Z) ? coord : head.entry.hi_z;
			face_q  <= pick;
			id_q    <= head.entry.id;
			last_q  <= (rest == '0);
		end
	end

	assign rect_out.valid       = out_valid_q;
	assign rect_out.rect_min_x  = min_x_q;
	assign rect_out.rect_min_y  = min_y_q;
	assign rect_out.rect_min_z  = min_z_q;
	assign rect_out.rect_max_x  = max_x_q;
	assign rect_out.rect_max_y  = max_y_q;
	assign rect_out.rect_max_z  = max_z_q;
	assign rect_out.face_code   = face_q;
	assign rect_out.linked_id   = id_q;
	assign rect_out.last_of_run = last_q;

	// a queued box always has a face left to send
	`BSFO_ASSERT_SAME(a_head_has_face, head.valid, rem != '0)
	// a sent rectangle is shown in the next cycle
	`BSFO_ASSERT_NEXT(a_emit_shows, emit, rect_out.valid)
	// the rectangle that retires a box closes its run
	`BSFO_ASSERT_NEXT(a_pop_is_last, pop, rect_out.last_of_run)

endmodule

// ----- rtl/box_shared_face_overlap_core.sv -----
// ----------------------------------------------------------------------------
// box_shared_face_overlap_core
// shared rectangles between the held box and a stream of other boxes
//
//   channel   dir  carries                         handshake
//   box_in    in   other box, other_id, same_box   valid / ready
//   rect_out  out  one rectangle, face, id, last   valid / ready
//   wr_*      in   held box register writes        wr_en, no wait
//
// a box is taken in any cycle in which the queue has a free slot
// the back end sends one rectangle per cycle unless rect_out stalls, one for each
// touching face of the head box (at most six); boxes without contact are never queued
// the first rectangle of a box passes through the queue and then the output register
// the queue lets the front keep taking boxes while rect_out is stalled
// reset clears the held box to zero and empties queue and output register
// ----------------------------------------------------------------------------
module box_shared_face_overlap_core #(
	parameter int unsigned QUEUE_DEPTH = bsfo_pkg::BSFO_QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bsfo_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [bsfo_pkg::COORD_W-1:0]     wr_data,
	bsfo_box_if.sink                         box_in,
	bsfo_rect_if.source                      rect_out
);
	import bsfo_pkg::*;

	own_box_t own_q;
	logic     q_full;
	logic     q_push;
	q_entry_t q_data;
	logic     q_pop;
	q_head_t  q_head;

	// held box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_OWN_MIN_X: own_q.min_x <= coord_t'(wr_data);
				REG_OWN_MIN_Y: own_q.min_y <= coord_t'(wr_data);
				REG_OWN_MIN_Z: own_q.min_z <= coord_t'(wr_data);
				REG_OWN_MAX_X: own_q.max_x <= coord_t'(wr_data);
				REG_OWN_MAX_Y: own_q.max_y <= coord_t'(wr_data);
				REG_OWN_MAX_Z: own_q.max_z <= coord_t'(wr_data);
				default: ;
			endcase
		end
	end

	// classify incoming boxes
	bsfo_front u_front (
		.box_in (box_in),
		.own    (own_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_data)
	);

	// decoupling queue
	bsfo_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.head      (q_head)
	);

	// emit rectangles
	bsfo_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.own      (own_q),
		.head     (q_head),
		.pop      (q_pop),
		.rect_out (rect_out)
	);

endmodule

// ----- bench/box_shared_face_overlap_core_tb.sv -----
// ----------------------------------------------------------------------------
// box_shared_face_overlap_core_tb
// self-checking bench for the shared face rectangle block
//
// a held box is loaded through the register port while the block is idle,
// then other boxes stream in. a short table covers reset state, each face
// alone, several faces at once, the same-box flag, boxes with no contact,
// full-range coordinates and inverted boxes. random phases follow with fresh
// held boxes. every rectangle is checked field by field against a bench
// predictor or a typed value, with random idle cycles on both channels and
// one long output stall that backs the block up
// ----------------------------------------------------------------------------
module box_shared_face_overlap_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsfo_pkg::*;

	localparam int unsigned RESET_CYCLES    = 10;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned LONG_HOLD       = 150;
	localparam int unsigned RAND_PHASES     = 4;
	localparam int unsigned ITEMS_PER_PHASE = 48;
	localparam int unsigned RUN_LIMIT_NS    = 6_000_000;

	// held box settings used by the table
	localparam logic [1:0] SET_RESET    = 2'd0;
	localparam logic [1:0] SET_UNIT     = 2'd1;
	localparam logic [1:0] SET_EXTREME  = 2'd2;
	localparam logic [1:0] SET_INVERTED = 2'd3;

	// register indexes past the held box, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam coord_t ONE   = 32'sh0001_0000;
	localparam coord_t HALF  = 32'sh0000_8000;
	localparam coord_t QTR   = 32'sh0000_4000;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam coord_t C_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		coord_t [2:0]    lo;
		coord_t [2:0]    hi;
		logic [ID_W-1:0] id;
		logic            same;
	} box_item_t;

	typedef struct packed {
		coord_t [2:0]      lo;
		coord_t [2:0]      hi;
		logic [FACE_W-1:0] face;
		logic [ID_W-1:0]   id;
		logic              last;
	} rect_t;

	typedef struct packed {
		logic [1:0]   setting;
		box_item_t    item;
		logic         typed;
		face_mask_t   mask;
		coord_t [2:0] elo;
		coord_t [2:0] ehi;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [COORD_W-1:0]   wr_data;

	bsfo_box_if  box_ch ();
	bsfo_rect_if rect_ch ();

	// bench copy of the held box
	coord_t [2:0] held_lo;
	coord_t [2:0] held_hi;

	rect_t       pending_rects[$];
	stim_row_t   dir_tab[$];
	int unsigned mismatch_cnt = 0;
	int unsigned send_calm = 0;
	logic        hold_ask = 1'b0;

	box_shared_face_overlap_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.box_in   (box_ch),
		.rect_out (rect_ch)
	);

	always #6 clk = ~clk;

	// signed helpers for the clamped overlap
	function automatic coord_t sgn_max(coord_t a, coord_t b);
		return ($signed(a) > $signed(b)) ? a : b;
	endfunction

	function automatic coord_t sgn_min(coord_t a, coord_t b);
		return ($signed(a) < $signed(b)) ? a : b;
	endfunction

	// mark the final rectangle of one box and queue the run
	function automatic void commit_run(rect_t found[$]);
		if (found.size() != 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[i])
			pending_rects.push_back(found[i]);
	endfunction

	// rectangles that one other box shares with the held box
	function automatic void predict_shared_rects(box_item_t b);
		rect_t      r;
		rect_t      found[$];
		logic [1:0] ax;
		logic       upper;
		coord_t     own_c;
		coord_t     oth_c;
		int         f;
		int         k;
		if (b.same)
			return;
		for (f = 0; f < FACE_COUNT; f++) begin
			case (f[FACE_W-1:0])
				FACE_TOP, FACE_BOTTOM: ax = AXIS_Y;
				FACE_LEFT, FACE_RIGHT: ax = AXIS_X;
				default:               ax = AXIS_Z;
			endcase
			upper = (f[FACE_W-1:0] == FACE_TOP) || (f[FACE_W-1:0] == FACE_LEFT) ||
				(f[FACE_W-1:0] == FACE_FRONT);
			own_c = upper ? held_hi[ax] : held_lo[ax];
			oth_c = upper ? b.lo[ax] : b.hi[ax];
			if (own_c == oth_c) begin
				for (k = 0; k < 3; k++) begin
					if (k == ax) begin
						r.lo[k] = own_c;
						r.hi[k] = own_c;
					end else begin
						r.lo[k] = sgn_max(b.lo[k], held_lo[k]);
						r.hi[k] = sgn_min(b.hi[k], held_hi[k]);
					end
				end
				r.face = f[FACE_W-1:0];
				r.id   = b.id;
				r.last = 1'b0;
				found.push_back(r);
			end
		end
		commit_run(found);
	endfunction

	// typed rows: one identical rectangle per listed face
	function automatic void queue_typed_rects(stim_row_t row);
		rect_t r;
		rect_t found[$];
		int    f;
		for (f = 0; f < FACE_COUNT; f++) begin
			if (row.mask[f]) begin
				r.lo   = row.elo;
				r.hi   = row.ehi;
				r.face = f[FACE_W-1:0];
				r.id   = row.item.id;
				r.last = 1'b0;
				found.push_back(r);
			end
		end
		commit_run(found);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			$display("%0t ns: %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int unsigned sender_gap();
		if (send_calm != 0) begin
			send_calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			send_calm = $urandom_range(10, 25);
		return idle_gap();
	endfunction

	// coordinate mix: full random, extremes, small grid values that collide often
	function automatic coord_t pick_coord();
		coord_t c;
		case ($urandom_range(0, 7))
			0, 1:    c = $urandom;
			2:       c = C_MIN;
			3:       c = C_MAX;
			default: c = coord_t'((int'($urandom_range(0, 16)) - 8) * 16384);
		endcase
		return c;
	endfunction

	// mostly boxes aligned to random held faces, some noise and same-box items
	function automatic box_item_t make_random_box();
		box_item_t   b;
		int unsigned kind;
		int          k;
		kind   = $urandom_range(0, 99);
		b.id   = 16'($urandom);
		b.same = (kind < 8);
		for (k = 0; k < 3; k++) begin
			if (kind < 20) begin
				b.lo[k] = $urandom;
				b.hi[k] = $urandom;
			end else begin
				b.lo[k] = ($urandom_range(0, 1) == 1) ? held_hi[k] : pick_coord();
				b.hi[k] = ($urandom_range(0, 1) == 1) ? held_lo[k] : pick_coord();
			end
		end
		return b;
	endfunction

	function automatic box_item_t mk_box(coord_t lx, coord_t ly, coord_t lz,
		coord_t hx, coord_t hy, coord_t hz, logic [ID_W-1:0] id, logic same);
		box_item_t b;
		b.lo[AXIS_X] = lx;
		b.lo[AXIS_Y] = ly;
		b.lo[AXIS_Z] = lz;
		b.hi[AXIS_X] = hx;
		b.hi[AXIS_Y] = hy;
		b.hi[AXIS_Z] = hz;
		b.id         = id;
		b.same       = same;
		return b;
	endfunction

	function automatic void add_pred(logic [1:0] setting, box_item_t b);
		stim_row_t row;
		row         = '0;
		row.setting = setting;
		row.item    = b;
		dir_tab.push_back(row);
	endfunction

	function automatic void add_typed(logic [1:0] setting, box_item_t b, face_mask_t mask,
		coord_t elx, coord_t ely, coord_t elz, coord_t ehx, coord_t ehy, coord_t ehz);
		stim_row_t row;
		row.setting     = setting;
		row.item        = b;
		row.typed       = 1'b1;
		row.mask        = mask;
		row.elo[AXIS_X] = elx;
		row.elo[AXIS_Y] = ely;
		row.elo[AXIS_Z] = elz;
		row.ehi[AXIS_X] = ehx;
		row.ehi[AXIS_Y] = ehy;
		row.ehi[AXIS_Z] = ehz;
		dir_tab.push_back(row);
	endfunction

	// directed table
	function automatic void build_table();
		// reset state: zero held box touches a zero box on every face
		add_typed(SET_RESET, mk_box(0, 0, 0, 0, 0, 0, 16'h0000, 1'b0), 6'h3F,
			0, 0, 0, 0, 0, 0);
		add_typed(SET_RESET, mk_box(0, 0, 0, 0, 0, 0, 16'hFFFF, 1'b1), 6'h00,
			0, 0, 0, 0, 0, 0);
		add_typed(SET_RESET, mk_box(1, 1, 1, 2, 2, 2, 16'h1234, 1'b0), 6'h00,
			0, 0, 0, 0, 0, 0);
		// unit cube: each face alone, two faces, all six, same box, no contact
		add_pred(SET_UNIT, mk_box(HALF, ONE, -HALF, ONE + HALF, ONE + ONE, HALF,
			16'h0001, 1'b0));
		add_pred(SET_UNIT, mk_box(-HALF, -ONE, QTR, HALF, 0, ONE - QTR, 16'h0002, 1'b0));
		add_pred(SET_UNIT, mk_box(ONE, 0, 0, ONE + ONE, ONE, ONE, 16'h0004, 1'b0));
		add_pred(SET_UNIT, mk_box(-ONE, QTR, QTR, 0, ONE - QTR, ONE - QTR, 16'h0008, 1'b0));
		add_pred(SET_UNIT, mk_box(0, 0, ONE, ONE, ONE, ONE + ONE, 16'h0010, 1'b0));
		add_pred(SET_UNIT, mk_box(0, 0, -ONE, ONE, ONE, 0, 16'h0020, 1'b0));
		add_pred(SET_UNIT, mk_box(ONE, ONE, 0, ONE + ONE, ONE + ONE, ONE, 16'h0040, 1'b0));
		add_pred(SET_UNIT, mk_box(ONE, ONE, ONE, 0, 0, 0, 16'h0080, 1'b0));
		add_typed(SET_UNIT, mk_box(ONE, ONE, ONE, 0, 0, 0, 16'h0100, 1'b1), 6'h00,
			0, 0, 0, 0, 0, 0);
		add_typed(SET_UNIT, mk_box(5 * ONE, 5 * ONE, 5 * ONE, 6 * ONE, 6 * ONE, 6 * ONE,
			16'h0200, 1'b0), 6'h00, 0, 0, 0, 0, 0, 0);
		// full-range held box
		add_typed(SET_EXTREME, mk_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX,
			16'hFFFF, 1'b0), 6'b000001, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX);
		add_typed(SET_EXTREME, mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
			16'h8000, 1'b0), 6'b100000, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
		add_pred(SET_EXTREME, mk_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
			16'h5555, 1'b0));
		// inverted held box
		add_pred(SET_INVERTED, mk_box(0, 0, 0, ONE, ONE, ONE, 16'hAAAA, 1'b0));
		add_pred(SET_INVERTED, mk_box(ONE, ONE, ONE, 0, 0, 0, 16'h00FF, 1'b0));
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			REG_OWN_MIN_X: held_lo[AXIS_X] = data;
			REG_OWN_MIN_Y: held_lo[AXIS_Y] = data;
			REG_OWN_MIN_Z: held_lo[AXIS_Z] = data;
			REG_OWN_MAX_X: held_hi[AXIS_X] = data;
			REG_OWN_MAX_Y: held_hi[AXIS_Y] = data;
			REG_OWN_MAX_Z: held_hi[AXIS_Z] = data;
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// stop offering, let every rectangle out, then let the pipe go quiet
	task automatic wait_drained();
		@(negedge clk);
		box_ch.valid <= 1'b0;
		while (pending_rects.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_held(input coord_t lx, input coord_t ly, input coord_t lz,
		input coord_t hx, input coord_t hy, input coord_t hz);
		wait_drained();
		write_reg(REG_OWN_MIN_X, lx);
		write_reg(REG_OWN_MIN_Y, ly);
		write_reg(REG_OWN_MIN_Z, lz);
		write_reg(REG_OWN_MAX_X, hx);
		write_reg(REG_OWN_MAX_Y, hy);
		write_reg(REG_OWN_MAX_Z, hz);
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
	endtask

	// offer one box after an idle gap and wait for its transfer
	task automatic send_box(input box_item_t b, input int unsigned gap);
		if (gap != 0) begin
			@(negedge clk);
			box_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		box_ch.other_min_x <= b.lo[AXIS_X];
		box_ch.other_min_y <= b.lo[AXIS_Y];
		box_ch.other_min_z <= b.lo[AXIS_Z];
		box_ch.other_max_x <= b.hi[AXIS_X];
		box_ch.other_max_y <= b.hi[AXIS_Y];
		box_ch.other_max_z <= b.hi[AXIS_Z];
		box_ch.other_id    <= b.id;
		box_ch.same_box    <= b.same;
		box_ch.valid       <= 1'b1;
		do
			@(posedge clk);
		while (box_ch.ready !== 1'b1);
	endtask

	// stimulus
	initial begin : box_sender
		box_item_t  b;
		logic [1:0] cur_setting;
		int         ph;
		int         n;
		arst_n             = 1'b0;
		wr_en              = 1'b0;
		wr_index           = '0;
		wr_data            = '0;
		box_ch.valid       = 1'b0;
		box_ch.other_min_x = '0;
		box_ch.other_min_y = '0;
		box_ch.other_min_z = '0;
		box_ch.other_max_x = '0;
		box_ch.other_max_y = '0;
		box_ch.other_max_z = '0;
		box_ch.other_id    = '0;
		box_ch.same_box    = 1'b0;
		held_lo            = '0;
		held_hi            = '0;
		build_table();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		cur_setting = SET_RESET;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].setting != cur_setting) begin
				cur_setting = dir_tab[i].setting;
				case (cur_setting)
					SET_UNIT:    load_held(0, 0, 0, ONE, ONE, ONE);
					SET_EXTREME: load_held(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
					default:     load_held(ONE, ONE, ONE, 0, 0, 0);
				endcase
			end
			send_box(dir_tab[i].item, sender_gap());
			if (dir_tab[i].typed)
				queue_typed_rects(dir_tab[i]);
			else
				predict_shared_rects(dir_tab[i].item);
		end

		// random phases, each with its own held box
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			load_held(pick_coord(), pick_coord(), pick_coord(),
				pick_coord(), pick_coord(), pick_coord());
			// long output stall while boxes keep coming
			if (ph == 1) begin
				hold_ask  = 1'b1;
				send_calm = 30;
			end
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				b = make_random_box();
				send_box(b, sender_gap());
				predict_shared_rects(b);
			end
		end

		wait_drained();
		if (mismatch_cnt == 0 && pending_rects.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// output ready with random gaps, calm stretches and one long hold
	initial begin : rect_receiver
		int unsigned gap_left;
		int unsigned calm_left;
		int unsigned hold_left;
		gap_left      = 0;
		calm_left     = 0;
		hold_left     = 0;
		rect_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				rect_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_ask) begin
				hold_ask      = 1'b0;
				hold_left     = LONG_HOLD - 1;
				rect_ch.ready <= 1'b0;
			end else if (gap_left != 0) begin
				rect_ch.ready <= 1'b0;
				gap_left--;
			end else begin
				rect_ch.ready <= 1'b1;
				if (calm_left != 0)
					calm_left--;
				else if ($urandom_range(0, 29) == 0)
					calm_left = $urandom_range(20, 60);
				else
					gap_left = idle_gap();
			end
		end
	end

	// compare each rectangle transfer with the oldest expectation
	always @(posedge clk) begin : rect_checker
		rect_t want;
		if (arst_n && rect_ch.valid === 1'b1 && rect_ch.ready === 1'b1) begin
			if (pending_rects.size() == 0) begin
				mismatch_cnt++;
				$display("%0t ns: rectangle with nothing pending, %s face %0d id %h",
					$time, "expected none actual", rect_ch.face_code, rect_ch.linked_id);
			end else begin
				want = pending_rects.pop_front();
				check_field("rect_min_x", want.lo[AXIS_X], rect_ch.rect_min_x);
				check_field("rect_min_y", want.lo[AXIS_Y], rect_ch.rect_min_y);
				check_field("rect_min_z", want.lo[AXIS_Z], rect_ch.rect_min_z);
				check_field("rect_max_x", want.hi[AXIS_X], rect_ch.rect_max_x);
				check_field("rect_max_y", want.hi[AXIS_Y], rect_ch.rect_max_y);
				check_field("rect_max_z", want.hi[AXIS_Z], rect_ch.rect_max_z);
				check_field("face_code", 32'(want.face), 32'(rect_ch.face_code));
				check_field("linked_id", 32'(want.id), 32'(rect_ch.linked_id));
				check_field("last_of_run", 32'(want.last), 32'(rect_ch.last_of_run));
			end
		end
	end

	// run limit
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule
